// ===== hw/rtl/lcts_pkg.sv =====
package lcts_pkg;

  // Field widths
  localparam int unsigned ACT_W    = 2;
  localparam int unsigned CH_W     = 4;
  localparam int unsigned RAW_W    = 24;
  localparam int unsigned GAIN_W   = 24;
  localparam int unsigned WEIGHT_W = 32;

  // Channel tables
  localparam int unsigned CHANNELS = 10;
  localparam int unsigned CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Tare accumulator
  localparam int unsigned TARE_SAMPLES = 50;
  localparam int unsigned SUM_W        = 31;
  localparam int unsigned CNT_W        = 6;
  localparam int unsigned DIV_REM_W    = $clog2(TARE_SAMPLES + 1) + 1;
  localparam int unsigned DIV_CNT_W    = $clog2(SUM_W + 1);

  // Filter coefficients, Q0.16
  localparam int unsigned ALPHA_ONE = 19661;
  localparam int unsigned ALPHA_TWO = 6554;

  // Serial multiplier: signed (x - s) times unsigned 24-bit multiplier
  localparam int unsigned MUL_STEPS = GAIN_W;
  localparam int unsigned MUL_CNT_W = $clog2(MUL_STEPS + 1);
  localparam int unsigned MC_W      = WEIGHT_W + 1;
  localparam int unsigned HI_W      = MC_W + 1;
  localparam int unsigned RND_SHIFT = 16;
  localparam int unsigned PROD_HI_W = HI_W + MUL_STEPS - RND_SHIFT;
  localparam int unsigned FIN_W     = PROD_HI_W + 1;

  typedef enum logic [ACT_W-1:0] {
    ACT_MEASURE = 2'd0,
    ACT_TARE    = 2'd1,
    ACT_INIT    = 2'd2,
    ACT_GAIN    = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL_SCALE,
    ST_WR_INIT,
    ST_EMA1_GO,
    ST_MUL_EMA1,
    ST_EMA2_GO,
    ST_MUL_EMA2,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                start;
    logic [WEIGHT_W-1:0] x;
    logic [WEIGHT_W-1:0] s;
    logic [GAIN_W-1:0]   m;
  } mul_req_t;

  typedef struct packed {
    logic                 done;
    logic [PROD_HI_W-1:0] prod_hi;
    logic                 rnd;
  } mul_rsp_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [RAW_W-1:0] quotient;
  } div_rsp_t;

  // Clamp a wide two's complement value to the signed weight range
  function automatic logic [WEIGHT_W-1:0] sat_weight(input logic [FIN_W-1:0] v);
    logic [FIN_W-WEIGHT_W:0] top;
    logic [WEIGHT_W-1:0]     res;
    top = v[FIN_W-1:WEIGHT_W-1];
    if ((&top) || !(|top)) begin
      res = v[WEIGHT_W-1:0];
    end else if (v[FIN_W-1]) begin
      res = {1'b1, {(WEIGHT_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(WEIGHT_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/lcts_if.sv =====
// Input word: action, channel, raw sample and gain
interface lcts_in_if;
  logic                              valid;
  logic                              ready;
  logic [lcts_pkg::ACT_W-1:0]        action;
  logic [lcts_pkg::CH_W-1:0]         channel;
  logic signed [lcts_pkg::RAW_W-1:0] raw_sample;
  logic [lcts_pkg::GAIN_W-1:0]       gain_recip;

  modport source(output valid, action, channel, raw_sample, gain_recip, input ready);
  modport sink(input valid, action, channel, raw_sample, gain_recip, output ready);
endinterface

// Result word: channel, filtered weight, tare completion flag
interface lcts_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [lcts_pkg::CH_W-1:0]            out_channel;
  logic signed [lcts_pkg::WEIGHT_W-1:0] weight;
  logic                                 tare_done;

  modport source(output valid, out_channel, weight, tare_done, input ready);
  modport sink(input valid, out_channel, weight, tare_done, output ready);
endinterface

// ===== hw/rtl/load_cell_tare_and_smoothing.sv =====
// Load cell conditioner for multiplexed converter channels.
// in_ch carries one word per converter event: action (measure, tare sample,
// filter init, load gain), channel, signed raw sample and Q0.24 gain.
// out_ch returns exactly one word per input word, in order: channel, stage
// two filtered weight (Q24.8, saturated) and a tare completion flag.
// Both channels use valid/ready; a word moves when both are high.
// One input word is processed at a time. A measure makes three passes through
// the shared 24-step shift-add multiplier (scaling, first filter, second
// filter) before the output load. Filter init makes the scaling pass only,
// and a tare word that completes the average runs the 31-step serial
// divider. The next word is taken in the cycle after a result is loaded.
// A new word is accepted as soon as the previous one has been written to
// the output register, so the next word can be in flight while a result
// waits. If out_ch.ready stays low the block holds its result and stops
// accepting once a second result is ready.
// Reset (rst_n low, synchronous) clears offsets, filter stages, the tare
// accumulator and the output valid; gains must be loaded before use.
module load_cell_tare_and_smoothing (
  input logic        clk,
  input logic        rst_n,
  lcts_in_if.sink    in_ch,
  lcts_out_if.source out_ch
);

  lcts_pkg::state_t  state_r;
  lcts_pkg::state_t  state_nxt;

  // latched item
  lcts_pkg::action_t                act_r;
  logic [lcts_pkg::CH_W-1:0]        ch_r;
  logic                             ch_ok_r;
  logic [lcts_pkg::RAW_W-1:0]       raw_r;
  logic [lcts_pkg::GAIN_W-1:0]      gain_in_r;
  logic                             tdone_r;

  // per-channel state
  logic [lcts_pkg::RAW_W-1:0]    offset_tab_r [lcts_pkg::CHANNELS];
  logic [lcts_pkg::GAIN_W-1:0]   gain_tab_r   [lcts_pkg::CHANNELS];
  logic [lcts_pkg::WEIGHT_W-1:0] s1_tab_r     [lcts_pkg::CHANNELS];
  logic [lcts_pkg::WEIGHT_W-1:0] s2_tab_r     [lcts_pkg::CHANNELS];

  // shared tare accumulator
  logic [lcts_pkg::SUM_W-1:0] tare_sum_r;
  logic [lcts_pkg::CNT_W-1:0] tare_cnt_r;

  logic [lcts_pkg::WEIGHT_W-1:0] fin_r;

  // output register
  logic                          out_valid_r;
  logic [lcts_pkg::CH_W-1:0]     out_ch_r;
  logic [lcts_pkg::WEIGHT_W-1:0] out_weight_r;
  logic                          out_done_r;

  logic [lcts_pkg::CH_IDX_W-1:0] idx;
  logic [lcts_pkg::RAW_W-1:0]    off_rd;
  logic [lcts_pkg::GAIN_W-1:0]   gain_rd;
  logic [lcts_pkg::WEIGHT_W-1:0] s1_rd;
  logic [lcts_pkg::WEIGHT_W-1:0] s2_rd;

  logic [lcts_pkg::SUM_W-1:0]    tare_sum_add;
  logic [lcts_pkg::CNT_W-1:0]    tare_cnt_inc;
  logic                          tare_full;

  logic [lcts_pkg::WEIGHT_W-1:0] fin_base;
  logic [lcts_pkg::FIN_W-1:0]    fin_sum;
  logic [lcts_pkg::WEIGHT_W-1:0] fin_val;

  lcts_pkg::mul_req_t mul_req;
  lcts_pkg::mul_rsp_t mul_rsp;
  lcts_pkg::div_req_t div_req;
  lcts_pkg::div_rsp_t div_rsp;

  logic in_ready;
  logic accept;
  logic load_out;
  logic wr_gain;
  logic wr_s1;
  logic wr_s2;
  logic wr_off;
  logic tare_upd;
  logic tare_clr;
  logic fin_ld;

  lcts_mul_serial u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  lcts_div_serial u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // table reads at the latched channel
  assign idx     = ch_r[lcts_pkg::CH_IDX_W-1:0];
  assign off_rd  = offset_tab_r[idx];
  assign gain_rd = gain_tab_r[idx];
  assign s1_rd   = s1_tab_r[idx];
  assign s2_rd   = s2_tab_r[idx];

  // tare accumulate
  assign tare_sum_add = tare_sum_r +
                        {{(lcts_pkg::SUM_W-lcts_pkg::RAW_W){raw_r[lcts_pkg::RAW_W-1]}}, raw_r};
  assign tare_cnt_inc = tare_cnt_r + lcts_pkg::CNT_W'(1);
  assign tare_full    = tare_cnt_inc >= lcts_pkg::CNT_W'(lcts_pkg::TARE_SAMPLES);

  // finish a multiply: base + round(product / 2^16), then saturate
  always_comb begin
    case (state_r)
      lcts_pkg::ST_MUL_EMA1: fin_base = s1_rd;
      lcts_pkg::ST_MUL_EMA2: fin_base = s2_rd;
      default:               fin_base = '0;
    endcase
  end

  assign fin_sum = {mul_rsp.prod_hi[lcts_pkg::PROD_HI_W-1], mul_rsp.prod_hi}
                 + {{(lcts_pkg::FIN_W-lcts_pkg::WEIGHT_W){fin_base[lcts_pkg::WEIGHT_W-1]}},
                    fin_base}
                 + lcts_pkg::FIN_W'(mul_rsp.rnd);
  assign fin_val = lcts_pkg::sat_weight(fin_sum);

  assign accept = in_ready && in_ch.valid;

  // sequencer
  always_comb begin
    state_nxt        = state_r;
    in_ready         = 1'b0;
    load_out         = 1'b0;
    wr_gain          = 1'b0;
    wr_s1            = 1'b0;
    wr_s2            = 1'b0;
    wr_off           = 1'b0;
    tare_upd         = 1'b0;
    tare_clr         = 1'b0;
    fin_ld           = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = tare_sum_add;
    mul_req          = '0;
    case (state_r)
      lcts_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          state_nxt = lcts_pkg::ST_EXEC;
        end
      end
      lcts_pkg::ST_EXEC: begin
        if (!ch_ok_r) begin
          state_nxt = lcts_pkg::ST_DONE;
        end else begin
          case (act_r)
            lcts_pkg::ACT_GAIN: begin
              wr_gain   = 1'b1;
              state_nxt = lcts_pkg::ST_DONE;
            end
            lcts_pkg::ACT_TARE: begin
              if (tare_full) begin
                tare_clr      = 1'b1;
                div_req.start = 1'b1;
                state_nxt     = lcts_pkg::ST_DIV;
              end else begin
                tare_upd  = 1'b1;
                state_nxt = lcts_pkg::ST_DONE;
              end
            end
            default: begin
              // measure and filter init both start with scaling
              mul_req.start = 1'b1;
              mul_req.x     = {{(lcts_pkg::WEIGHT_W-lcts_pkg::RAW_W){raw_r[lcts_pkg::RAW_W-1]}},
                               raw_r};
              mul_req.s     = {{(lcts_pkg::WEIGHT_W-lcts_pkg::RAW_W){off_rd[lcts_pkg::RAW_W-1]}},
                               off_rd};
              mul_req.m     = gain_rd;
              state_nxt     = lcts_pkg::ST_MUL_SCALE;
            end
          endcase
        end
      end
      lcts_pkg::ST_MUL_SCALE: begin
        if (mul_rsp.done) begin
          fin_ld    = 1'b1;
          state_nxt = (act_r == lcts_pkg::ACT_INIT) ? lcts_pkg::ST_WR_INIT
                                                    : lcts_pkg::ST_EMA1_GO;
        end
      end
      lcts_pkg::ST_WR_INIT: begin
        wr_s1     = 1'b1;
        state_nxt = lcts_pkg::ST_DONE;
      end
      lcts_pkg::ST_EMA1_GO: begin
        mul_req.start = 1'b1;
        mul_req.x     = fin_r;
        mul_req.s     = s1_rd;
        mul_req.m     = lcts_pkg::GAIN_W'(lcts_pkg::ALPHA_ONE);
        state_nxt     = lcts_pkg::ST_MUL_EMA1;
      end
      lcts_pkg::ST_MUL_EMA1: begin
        if (mul_rsp.done) begin
          fin_ld    = 1'b1;
          state_nxt = lcts_pkg::ST_EMA2_GO;
        end
      end
      lcts_pkg::ST_EMA2_GO: begin
        // new stage one is stored and feeds stage two
        wr_s1         = 1'b1;
        mul_req.start = 1'b1;
        mul_req.x     = fin_r;
        mul_req.s     = s2_rd;
        mul_req.m     = lcts_pkg::GAIN_W'(lcts_pkg::ALPHA_TWO);
        state_nxt     = lcts_pkg::ST_MUL_EMA2;
      end
      lcts_pkg::ST_MUL_EMA2: begin
        if (mul_rsp.done) begin
          wr_s2     = 1'b1;
          state_nxt = lcts_pkg::ST_DONE;
        end
      end
      lcts_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          wr_off    = 1'b1;
          state_nxt = lcts_pkg::ST_DONE;
        end
      end
      lcts_pkg::ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          load_out  = 1'b1;
          state_nxt = lcts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lcts_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lcts_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r     <= lcts_pkg::action_t'(in_ch.action);
      ch_r      <= in_ch.channel;
      ch_ok_r   <= {1'b0, in_ch.channel} < (lcts_pkg::CH_W + 1)'(lcts_pkg::CHANNELS);
      raw_r     <= in_ch.raw_sample;
      gain_in_r <= in_ch.gain_recip;
    end
    if (fin_ld) begin
      fin_r <= fin_val;
    end
  end

  // tare completion flag for the current word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tdone_r <= 1'b0;
    end else if (accept) begin
      tdone_r <= 1'b0;
    end else if (wr_off) begin
      tdone_r <= 1'b1;
    end
  end

  // offsets, filter stages and tare accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < lcts_pkg::CHANNELS; i++) begin
        offset_tab_r[i] <= '0;
        s1_tab_r[i]     <= '0;
        s2_tab_r[i]     <= '0;
      end
      tare_sum_r <= '0;
      tare_cnt_r <= '0;
    end else begin
      if (wr_off) begin
        offset_tab_r[idx] <= div_rsp.quotient;
      end
      if (wr_s1) begin
        s1_tab_r[idx] <= fin_r;
      end
      if (wr_s2) begin
        s2_tab_r[idx] <= fin_val;
      end
      if (tare_clr) begin
        tare_sum_r <= '0;
        tare_cnt_r <= '0;
      end else if (tare_upd) begin
        tare_sum_r <= tare_sum_add;
        tare_cnt_r <= tare_cnt_inc;
      end
    end
  end

  // gains hold no reset value
  always_ff @(posedge clk) begin
    if (wr_gain) begin
      gain_tab_r[idx] <= gain_in_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_ch_r     <= ch_r;
      out_weight_r <= ch_ok_r ? s2_rd : '0;
      out_done_r   <= tdone_r;
    end
  end

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_channel = out_ch_r;
  assign out_ch.weight      = out_weight_r;
  assign out_ch.tare_done   = out_done_r;

endmodule

// ===== hw/rtl/lcts_mul_serial.sv =====
// Shift-add multiplier: (x - s) * m, one multiplier bit per cycle
module lcts_mul_serial (
  input  logic               clk,
  input  logic               rst_n,
  input  lcts_pkg::mul_req_t req,
  output lcts_pkg::mul_rsp_t rsp
);

  logic [lcts_pkg::MC_W-1:0]      mc_r;
  logic [lcts_pkg::HI_W-1:0]      hi_r;
  logic [lcts_pkg::MUL_STEPS-1:0] q_r;
  logic [lcts_pkg::MUL_CNT_W-1:0] cnt_r;
  logic                           busy_r;
  logic                           done_r;

  logic [lcts_pkg::HI_W-1:0] mc_ext;
  logic [lcts_pkg::HI_W-1:0] addend;
  logic [lcts_pkg::HI_W-1:0] hi_sum;
  logic                      last;

  // partial product add for the current multiplier bit
  assign mc_ext = {mc_r[lcts_pkg::MC_W-1], mc_r};
  assign addend = q_r[0] ? mc_ext : '0;
  assign hi_sum = hi_r + addend;
  assign last   = busy_r && (cnt_r == lcts_pkg::MUL_CNT_W'(1));

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= last;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (last) begin
        busy_r <= 1'b0;
      end
    end
  end

  // datapath: {hi, q} shifts right one place per step
  always_ff @(posedge clk) begin
    if (req.start) begin
      mc_r  <= {req.x[lcts_pkg::WEIGHT_W-1], req.x} - {req.s[lcts_pkg::WEIGHT_W-1], req.s};
      hi_r  <= '0;
      q_r   <= req.m;
      cnt_r <= lcts_pkg::MUL_CNT_W'(lcts_pkg::MUL_STEPS);
    end else if (busy_r) begin
      hi_r  <= {hi_sum[lcts_pkg::HI_W-1], hi_sum[lcts_pkg::HI_W-1:1]};
      q_r   <= {hi_sum[0], q_r[lcts_pkg::MUL_STEPS-1:1]};
      cnt_r <= cnt_r - lcts_pkg::MUL_CNT_W'(1);
    end
  end

  // product shifted down 16 places plus the rounding bit
  assign rsp.done    = done_r;
  assign rsp.prod_hi = {hi_r, q_r[lcts_pkg::MUL_STEPS-1:lcts_pkg::RND_SHIFT]};
  assign rsp.rnd     = q_r[lcts_pkg::RND_SHIFT-1];

endmodule

// ===== hw/rtl/lcts_div_serial.sv =====
// Restoring divide of the tare sum by the sample count, one quotient bit per cycle
module lcts_div_serial (
  input  logic               clk,
  input  logic               rst_n,
  input  lcts_pkg::div_req_t req,
  output lcts_pkg::div_rsp_t rsp
);

  logic                           neg_r;
  logic [lcts_pkg::DIV_REM_W-1:0] rem_r;
  logic [lcts_pkg::SUM_W-1:0]     quo_r;
  logic [lcts_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                           busy_r;
  logic                           done_r;

  logic [lcts_pkg::SUM_W-1:0]     mag;
  logic [lcts_pkg::DIV_REM_W-1:0] rem2;
  logic                           take;
  logic                           last;
  logic [lcts_pkg::RAW_W-1:0]     quo_lo;

  // magnitude in, sign restored at the end: truncation toward zero
  assign mag  = req.dividend[lcts_pkg::SUM_W-1] ? ('0 - req.dividend) : req.dividend;
  assign rem2 = {rem_r[lcts_pkg::DIV_REM_W-2:0], quo_r[lcts_pkg::SUM_W-1]};
  assign take = rem2 >= lcts_pkg::DIV_REM_W'(lcts_pkg::TARE_SAMPLES);
  assign last = busy_r && (cnt_r == lcts_pkg::DIV_CNT_W'(1));

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= last;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (last) begin
        busy_r <= 1'b0;
      end
    end
  end

  // dividend shifts out of the top of quo_r as quotient bits enter below
  always_ff @(posedge clk) begin
    if (req.start) begin
      neg_r <= req.dividend[lcts_pkg::SUM_W-1];
      rem_r <= '0;
      quo_r <= mag;
      cnt_r <= lcts_pkg::DIV_CNT_W'(lcts_pkg::SUM_W);
    end else if (busy_r) begin
      rem_r <= take ? (rem2 - lcts_pkg::DIV_REM_W'(lcts_pkg::TARE_SAMPLES)) : rem2;
      quo_r <= {quo_r[lcts_pkg::SUM_W-2:0], take};
      cnt_r <= cnt_r - lcts_pkg::DIV_CNT_W'(1);
    end
  end

  assign quo_lo       = quo_r[lcts_pkg::RAW_W-1:0];
  assign rsp.done     = done_r;
  assign rsp.quotient = neg_r ? ('0 - quo_lo) : quo_lo;

endmodule
